@@ design/fconv_pkg.sv @@
package fconv_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Fixed field widths of the result and input items.
    localparam int VALUE_BITS  = 37;
    localparam int POS_BITS    = 6;
    localparam int CMD_BITS    = 2;
    localparam int IN_BITS     = 16;

    // Lengths hold 0..32, indexes 0..31, for any capacity in range.
    localparam int LEN_BITS    = 6;
    localparam int IDX_BITS    = 5;

    typedef struct packed {
        logic                  load_a;
        logic                  load_b;
        logic                  rd_en;
        logic [IDX_BITS-1:0]   idx_a;
        logic [IDX_BITS-1:0]   idx_b;
        logic                  acc_clr;
        logic                  emit;
        logic                  emit_last;
        logic                  emit_empty;
        logic [POS_BITS-1:0]   emit_pos;
    } t_dp_cmd;

    typedef struct packed {
        logic [LEN_BITS-1:0]   len_a;
        logic [LEN_BITS-1:0]   len_b;
        logic                  pipe_busy;
        logic                  out_free;
    } t_dp_sts;

endpackage

@@ design/fconv_dp.sv @@
module fconv_dp #(
    parameter int MAX_LEN     = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fconv_pkg::t_dp_cmd                   i_cmd,
    output fconv_pkg::t_dp_sts                   o_sts,
    input  logic signed [fconv_pkg::IN_BITS-1:0] i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fconv_pkg::VALUE_BITS-1:0] o_value,
    output logic [fconv_pkg::POS_BITS-1:0]       o_position,
    output logic                                 o_last,
    output logic                                 o_empty_res,
    output logic                                 o_dropped
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int XW = (PW > fconv_pkg::VALUE_BITS) ? PW : fconv_pkg::VALUE_BITS;
    localparam int SW = (SAMPLE_BITS > fconv_pkg::IN_BITS) ? SAMPLE_BITS
                                                           : fconv_pkg::IN_BITS;
    localparam logic [fconv_pkg::LEN_BITS-1:0] FULL = fconv_pkg::LEN_BITS'(MAX_LEN);

    logic signed [SAMPLE_BITS-1:0] mem_a [MAX_LEN];
    logic signed [SAMPLE_BITS-1:0] mem_b [MAX_LEN];

    logic [fconv_pkg::LEN_BITS-1:0] r_len_a, r_len_b;
    logic                           r_ovf;
    logic signed [SAMPLE_BITS-1:0]  r_ra, r_rb;
    logic signed [PW-1:0]           r_prod;
    logic                           r_v1, r_v2;
    logic signed [fconv_pkg::VALUE_BITS-1:0] r_acc;
    logic                           r_out_valid;
    logic signed [fconv_pkg::VALUE_BITS-1:0] r_value;
    logic [fconv_pkg::POS_BITS-1:0] r_pos;
    logic                           r_last, r_empty, r_dropped;

    logic signed [SW-1:0]           sample_ext;
    logic signed [SAMPLE_BITS-1:0]  sample_cut;
    logic signed [XW-1:0]           prod_ext;
    logic                           out_free;

    // Sign-extend the sample, then keep the storage width (wraps when narrower).
    assign sample_ext = SW'(i_sample);
    assign sample_cut = sample_ext[SAMPLE_BITS-1:0];
    assign prod_ext   = XW'(r_prod);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && (r_len_a < FULL)) begin
            mem_a[r_len_a[AW-1:0]] <= sample_cut;
        end
        if (i_cmd.load_b && (r_len_b < FULL)) begin
            mem_b[r_len_b[AW-1:0]] <= sample_cut;
        end
        r_ra <= mem_a[i_cmd.idx_a[AW-1:0]];
        r_rb <= mem_b[i_cmd.idx_b[AW-1:0]];
        r_prod <= r_ra * r_rb;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + prod_ext[fconv_pkg::VALUE_BITS-1:0];
        end
        if (i_cmd.emit) begin
            r_value   <= i_cmd.emit_empty ? '0 : r_acc;
            r_pos     <= i_cmd.emit_pos;
            r_last    <= i_cmd.emit_last;
            r_empty   <= i_cmd.emit_empty;
            r_dropped <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.load_a) begin
                if (r_len_a < FULL) begin
                    r_len_a <= r_len_a + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load_b) begin
                if (r_len_b < FULL) begin
                    r_len_b <= r_len_b + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            // The final item of a run clears both vectors and the drop flag.
            if (i_cmd.emit && i_cmd.emit_last) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.len_a     = r_len_a;
    assign o_sts.len_b     = r_len_b;
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_position  = r_pos;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;
    assign o_dropped   = r_dropped;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result written while output register is held");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.emit_last) |=> (r_len_a == '0 && r_len_b == '0 && !r_ovf))
        else $error("vectors not cleared after the final item");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= FULL) && (r_len_b <= FULL))
        else $error("vector length beyond capacity");

endmodule

@@ design/fconv_ctrl.sv @@
module fconv_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fconv_pkg::CMD_BITS-1:0]      i_command,
    input  fconv_pkg::t_dp_sts                  i_sts,
    output fconv_pkg::t_dp_cmd                  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam int LB = fconv_pkg::LEN_BITS;
    localparam int IB = fconv_pkg::IDX_BITS;

    logic [1:0]    r_state, n_state;
    logic [LB-1:0] r_k, n_k;
    logic [IB-1:0] r_i, n_i;
    logic          r_empty, n_empty;

    logic          accept;
    logic [LB-1:0] na, nb, k_nx, hi_full, lo_full, j_full;
    logic [LB:0]   terms_sum;
    logic          is_last;

    assign accept = i_in_valid && !o_in_stall;
    assign na     = i_sts.len_a;
    assign nb     = i_sts.len_b;
    assign k_nx   = r_k + 1'b1;

    // Overlap of term k: i runs from max(0, k-nb+1) to min(k, na-1).
    assign hi_full = (r_k < na) ? r_k : (na - 1'b1);
    assign lo_full = (k_nx >= nb) ? (k_nx - nb + 1'b1) : '0;
    assign j_full  = r_k - {1'b0, r_i};

    assign terms_sum = {1'b0, na} + {1'b0, nb};
    assign is_last   = r_empty || (({1'b0, r_k} + 2'd2) == terms_sum);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_empty = r_empty;
        o_cmd   = '0;
        o_cmd.idx_a      = r_i;
        o_cmd.idx_b      = j_full[IB-1:0];
        o_cmd.emit_pos   = r_k;
        o_cmd.emit_last  = is_last;
        o_cmd.emit_empty = r_empty;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        fconv_pkg::CMD_LOAD_A: o_cmd.load_a = 1'b1;
                        fconv_pkg::CMD_LOAD_B: o_cmd.load_b = 1'b1;
                        fconv_pkg::CMD_COMPUTE: begin
                            n_k           = '0;
                            n_i           = '0;
                            o_cmd.acc_clr = 1'b1;
                            if (na == '0 || nb == '0) begin
                                n_empty = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                n_empty = 1'b0;
                                n_state = S_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                if (r_i == hi_full[IB-1:0]) begin
                    n_state = S_DRAIN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = k_nx;
                        n_i     = lo_full[IB-1:0];
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_empty <= n_empty;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.pipe_busy)
        else $error("result written before the products were summed");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> ({1'b0, r_i} < na && j_full < nb))
        else $error("read outside the loaded vectors");

endmodule

@@ design/full_linear_convolution.sv @@
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_command, i_sample
// out       output     o_out_valid / i_out_stall  o_value, o_position, o_last,
//                                                 o_empty_res, o_dropped
//
// A compute of lengths na and nb walks each product once through the single
// multiply-accumulate; each term passes the read, multiply and accumulate
// registers before the output register takes it.
// Reset is synchronous and active low; it clears both lengths and the drop flag.
// The input is stalled during a compute; a stalled output item holds the run.
module full_linear_convolution #(
    parameter int MAX_LEN     = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [fconv_pkg::CMD_BITS-1:0]          i_command,
    input  logic signed [fconv_pkg::IN_BITS-1:0]    i_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [fconv_pkg::VALUE_BITS-1:0] o_value,
    output logic [fconv_pkg::POS_BITS-1:0]          o_position,
    output logic                                    o_last,
    output logic                                    o_empty_res,
    output logic                                    o_dropped
);

    fconv_pkg::t_dp_cmd dp_cmd;
    fconv_pkg::t_dp_sts dp_sts;

    fconv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    fconv_dp #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_position  (o_position),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_dropped   (o_dropped)
    );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN        = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam logic [fconv_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT       = 29;
    localparam int ITEM_TARGET    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CALM_FROM      = 1000;
    localparam int CALM_TO        = 2500;

    typedef enum int {FILL_RANDOM, FILL_MIN, FILL_EXTREME} t_fill_mode;

    typedef struct packed {
        logic [fconv_pkg::CMD_BITS-1:0] cmd;
        logic [fconv_pkg::IN_BITS-1:0]  smp;
    } t_conv_item;

    typedef struct packed {
        logic [fconv_pkg::VALUE_BITS-1:0] value;
        logic [fconv_pkg::POS_BITS-1:0]   pos;
        logic                             last;
        logic                             empty;
        logic                             dropped;
    } t_conv_term;

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_in_valid = 1'b0;
    logic                                    o_in_stall;
    logic [fconv_pkg::CMD_BITS-1:0]          i_command = fconv_pkg::CMD_LOAD_A;
    logic signed [fconv_pkg::IN_BITS-1:0]    i_sample = '0;
    logic                                    o_out_valid;
    logic                                    i_out_stall = 1'b0;
    logic signed [fconv_pkg::VALUE_BITS-1:0] o_value;
    logic [fconv_pkg::POS_BITS-1:0]          o_position;
    logic                                    o_last;
    logic                                    o_empty_res;
    logic                                    o_dropped;

    full_linear_convolution #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_position  (o_position),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_dropped   (o_dropped)
    );

    t_conv_item pending_items[$];
    t_conv_term expected_terms[$];

    // Shadow copy of the two sample vectors and their lengths.
    logic signed [SAMPLE_BITS-1:0] vec_a [MAX_LEN];
    logic signed [SAMPLE_BITS-1:0] vec_b [MAX_LEN];
    int len_a = 0;
    int len_b = 0;
    bit drop_seen = 1'b0;

    int  items_queued = 0;
    int  items_taken = 0;
    int  terms_seen = 0;
    int  computes_done = 0;
    int  drop_runs = 0;
    int  max_terms = 0;
    int  errors = 0;
    int  cycle_cnt = 0;
    int  quiet_cycles = 0;
    bit  in_taken = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic convolve_item(input logic [fconv_pkg::CMD_BITS-1:0] cmd,
                                 input logic signed [fconv_pkg::IN_BITS-1:0] smp);
        t_conv_term t;
        longint     acc;
        int         n_terms;
        int         j;
        case (cmd)
            fconv_pkg::CMD_LOAD_A: begin
                if (len_a >= MAX_LEN) begin
                    drop_seen = 1'b1;
                end else begin
                    vec_a[len_a] = SAMPLE_BITS'(smp);
                    len_a++;
                end
            end
            fconv_pkg::CMD_LOAD_B: begin
                if (len_b >= MAX_LEN) begin
                    drop_seen = 1'b1;
                end else begin
                    vec_b[len_b] = SAMPLE_BITS'(smp);
                    len_b++;
                end
            end
            fconv_pkg::CMD_COMPUTE: begin
                if (drop_seen)
                    drop_runs++;
                if (len_a == 0 || len_b == 0) begin
                    t = '{value: '0, pos: '0, last: 1'b1, empty: 1'b1, dropped: drop_seen};
                    expected_terms.push_back(t);
                    n_terms = 1;
                end else begin
                    n_terms = len_a + len_b - 1;
                    for (int k = 0; k < n_terms; k++) begin
                        acc = 0;
                        for (int i = 0; i < len_a && i <= k; i++) begin
                            j = k - i;
                            if (j < len_b)
                                acc += longint'(vec_a[i]) * longint'(vec_b[j]);
                        end
                        t.value   = acc[fconv_pkg::VALUE_BITS-1:0];
                        t.pos     = fconv_pkg::POS_BITS'(k);
                        t.last    = (k == n_terms - 1);
                        t.empty   = 1'b0;
                        t.dropped = drop_seen;
                        expected_terms.push_back(t);
                    end
                end
                if (n_terms > max_terms)
                    max_terms = n_terms;
                len_a = 0;
                len_b = 0;
                drop_seen = 1'b0;
                computes_done++;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: accepts items on both channels, predicts and checks.
    always @(posedge i_clk) begin
        t_conv_term want;
        if (i_rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            in_taken  <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                convolve_item(i_command, i_sample);
                items_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                terms_seen++;
                if (expected_terms.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output item, expected none, actual value %0d position %0d",
                             $time, o_value, o_position);
                end else begin
                    want = expected_terms.pop_front();
                    check_field("value", $signed(want.value), o_value);
                    check_field("position", want.pos, o_position);
                    check_field("last", want.last, o_last);
                    check_field("empty_res", want.empty, o_empty_res);
                    check_field("dropped", want.dropped, o_dropped);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Driver: presents queued items and randomly stalls the output.
    always @(negedge i_clk) begin
        t_conv_item nxt;
        bit         calm;
        calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);
        if (i_rst_n) begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_command  <= nxt.cmd;
                    i_sample   <= nxt.smp;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic queue_item(input logic [fconv_pkg::CMD_BITS-1:0] cmd,
                              input logic [fconv_pkg::IN_BITS-1:0] smp);
        t_conv_item it;
        it.cmd = cmd;
        it.smp = smp;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [fconv_pkg::IN_BITS-1:0] pick_sample(input t_fill_mode mode);
        case (mode)
            FILL_MIN: return 16'h8000;
            FILL_EXTREME: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return fconv_pkg::IN_BITS'($urandom);
                endcase
            end
            default: return fconv_pkg::IN_BITS'($urandom);
        endcase
    endfunction

    // One load sequence for both vectors in random order, ended by a compute.
    // A few sequences run past capacity to exercise dropped loads.
    task automatic queue_random_run(input bit force_full);
        int         na;
        int         nb;
        int         ia;
        int         ib;
        t_fill_mode mode;
        if (force_full) begin
            na = MAX_LEN + 1;
            nb = MAX_LEN + 2;
            mode = FILL_MIN;
        end else if ($urandom_range(9) == 0) begin
            na = $urandom_range(MAX_LEN + 2, MAX_LEN - 4);
            nb = $urandom_range(MAX_LEN + 2, MAX_LEN - 4);
            mode = t_fill_mode'($urandom_range(2));
        end else begin
            na = $urandom_range(5);
            nb = $urandom_range(5);
            mode = t_fill_mode'($urandom_range(2));
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if ($urandom_range(19) == 0)
                queue_item(CMD_UNUSED, fconv_pkg::IN_BITS'($urandom));
            if (ia < na && (ib >= nb || $urandom_range(1) == 1)) begin
                queue_item(fconv_pkg::CMD_LOAD_A, pick_sample(mode));
                ia++;
            end else begin
                queue_item(fconv_pkg::CMD_LOAD_B, pick_sample(mode));
                ib++;
            end
        end
        queue_item(fconv_pkg::CMD_COMPUTE, fconv_pkg::IN_BITS'($urandom));
    endtask

    initial begin
        // Empty vectors, one-sided loads and the unused command.
        queue_item(fconv_pkg::CMD_COMPUTE, 16'h0000);
        queue_item(CMD_UNUSED, 16'h7FFF);
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h7FFF);
        queue_item(fconv_pkg::CMD_COMPUTE, 16'hFFFF);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'h8000);
        queue_item(fconv_pkg::CMD_COMPUTE, 16'h8000);
        // Single-term products at the sample extremes.
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h8000);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'h8000);
        queue_item(fconv_pkg::CMD_COMPUTE, 16'h0000);
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h7FFF);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'h8000);
        queue_item(fconv_pkg::CMD_COMPUTE, 16'h0000);
        // Short vectors with a stray unused command in the middle.
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h7FFF);
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h8000);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'h7FFF);
        queue_item(fconv_pkg::CMD_LOAD_A, 16'hFFFF);
        queue_item(CMD_UNUSED, 16'h8000);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'h0000);
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h0001);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'hFFFF);
        queue_item(fconv_pkg::CMD_COMPUTE, 16'h5555);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'h0005);
        queue_item(fconv_pkg::CMD_LOAD_A, 16'h0007);
        queue_item(fconv_pkg::CMD_LOAD_B, 16'hFFFD);
        queue_item(fconv_pkg::CMD_COMPUTE, 16'hAAAA);

        queue_random_run(1'b1);
        while (items_queued < ITEM_TARGET)
            queue_random_run(1'b0);

        @(posedge i_rst_n);
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_items.size() != 0 || i_in_valid || expected_terms.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input items over %0d computes, %0d of them after dropped loads.",
                 items_taken, computes_done, drop_runs);
        $display("Checked %0d convolution terms, the longest run giving %0d terms.",
                 terms_seen, max_terms);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
